>>> rtl/core/wmf_pkg.sv
// wmf_pkg: shared types and sizes of the window median filter
// depends on nothing; used by every module under rtl/core but wmf_ram
`default_nettype none

package wmf_pkg;

    localparam int WINDOW       = 3;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_HEIGHT   = 4096;

    localparam int SAMPLE_W   = 8;
    localparam int TAPS       = WINDOW * WINDOW;
    localparam int LINE_DEPTH = WINDOW - 1;
    localparam int WIN_OLD    = (WINDOW - 1) * WINDOW;
    localparam int RANK_W     = $clog2(TAPS);

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CHAN_REG_W   = 3;
    localparam int CFG_DATA_W   = 13;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    // wide enough for any limit, any register value and a counter plus one
    localparam int CMP_W = $clog2((MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH) + 2;

    localparam int LS_ADDR_W = CH_W + COL_W;
    localparam int LS_DEPTH  = 2 ** LS_ADDR_W;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                frame_start;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic                frame_done;
    } out_item_t;

    // position of the item being accepted
    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
    } pos_t;

    typedef logic [LINE_DEPTH-1:0][SAMPLE_W-1:0] line_t;
    typedef logic [WINDOW-1:0][SAMPLE_W-1:0]     column_t;
    typedef logic [WIN_OLD-1:0][SAMPLE_W-1:0]    win_t;
    typedef logic [TAPS-1:0][SAMPLE_W-1:0]       taps_t;

endpackage

`default_nettype wire

>>> rtl/core/window_median_filter.sv
// window_median_filter: top level of the streaming window median filter
// depends on wmf_pkg, wmf_position, wmf_ram, wmf_median
//
// Streaming WINDOW x WINDOW median filter for raster-ordered 8-bit samples with
// interleaved channels. One item is taken every clock unless an unaccepted result
// stalls stage one; a result passes stage one (position and line store read),
// then the output register (window update and median). Items whose same-channel
// neighbourhood (ending at the item, as bottom-right corner) is not fully inside
// the frame give no result; frame_done marks the last median of a frame. The
// earlier rows live in one ram of (channels x width) words, read at acceptance
// and written back as the item leaves stage one, with a forward path for back
// to back items at the same address. The ram needs no clearing after reset. The
// configuration port is always ready and must only be written while idle.
`default_nettype none

module window_median_filter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire wmf_pkg::cfg_index_t            cfg_index,
    input  wire logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample items in
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire wmf_pkg::in_item_t              s_item,
    // median items out
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output wmf_pkg::out_item_t                  m_item
);

    localparam int AW = wmf_pkg::LS_ADDR_W;

    logic          s_accept;
    wmf_pkg::pos_t pos;
    logic [AW-1:0] rd_addr;

    // stage one: item waiting for its line store data
    logic                         s1_valid_reg;
    logic [wmf_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic [wmf_pkg::CH_W-1:0]     s1_ch_reg;
    logic                         s1_emit_reg;
    logic                         s1_last_reg;
    logic                         s1_fwd_hit_reg;
    wmf_pkg::line_t               s1_fwd_data_reg;
    logic                         s1_adv;

    // output register
    logic               m_valid_reg;
    wmf_pkg::out_item_t m_item_reg;

    wmf_pkg::line_t   ram_rdata;
    wmf_pkg::line_t   line_rd;
    wmf_pkg::line_t   line_wr;
    wmf_pkg::column_t vert;
    wmf_pkg::taps_t   taps;
    wmf_pkg::win_t    win_next;
    wmf_pkg::win_t    win_reg [wmf_pkg::MAX_CHANNELS];

    logic [wmf_pkg::SAMPLE_W-1:0] median;

    assign cfg_ready = 1'b1;

    // stage one moves on unless its result has nowhere to go
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    wmf_position u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .advance     (s_accept),
        .frame_start (s_item.frame_start),
        .pos         (pos)
    );

    assign rd_addr = {pos.ch, pos.col};

    // earlier rows, one word per column and channel, oldest row lowest
    wmf_ram #(
        .DATA_W ($bits(wmf_pkg::line_t)),
        .DEPTH  (wmf_pkg::LS_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (line_wr),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // vertical column and the window of this item's channel
    always_comb begin
        line_rd = s1_fwd_hit_reg ? s1_fwd_data_reg : ram_rdata;
        for (int k = 0; k < wmf_pkg::LINE_DEPTH; k++) begin
            vert[k] = line_rd[k];
        end
        vert[wmf_pkg::WINDOW-1] = s1_sample_reg;
        for (int k = 0; k < wmf_pkg::LINE_DEPTH; k++) begin
            line_wr[k] = vert[k+1];
        end
        for (int t = 0; t < wmf_pkg::WIN_OLD; t++) begin
            taps[t] = win_reg[s1_ch_reg][t];
        end
        for (int k = 0; k < wmf_pkg::WINDOW; k++) begin
            taps[wmf_pkg::WIN_OLD + k] = vert[k];
        end
        // slide one column: oldest drops out
        for (int t = 0; t < wmf_pkg::WIN_OLD; t++) begin
            win_next[t] = taps[t + wmf_pkg::WINDOW];
        end
    end

    wmf_median u_median (
        .taps   (taps),
        .median (median)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // payload of stage one; the forward covers a write-back in the read cycle
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_sample_reg   <= s_item.sample;
            s1_addr_reg     <= rd_addr;
            s1_ch_reg       <= pos.ch;
            s1_emit_reg     <= pos.emit;
            s1_last_reg     <= pos.last;
            s1_fwd_hit_reg  <= s1_valid_reg && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= line_wr;
        end
    end

    // per-channel windows, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < wmf_pkg::MAX_CHANNELS; c++) begin
                win_reg[c] <= '0;
            end
        end else if (s1_adv) begin
            win_reg[s1_ch_reg] <= win_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            m_item_reg.median     <= median;
            m_item_reg.frame_done <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

>>> rtl/core/wmf_ram.sv
// wmf_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing; read during a write to the same address returns old data
`default_nettype none

module wmf_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/wmf_position.sv
// wmf_position: configuration registers and raster position counters
// depends on wmf_pkg
`default_nettype none

module wmf_position (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire wmf_pkg::cfg_index_t           cfg_index,
    input  wire logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          advance,
    input  wire logic                          frame_start,
    output wmf_pkg::pos_t                      pos
);

    localparam int CW = wmf_pkg::CMP_W;

    logic [wmf_pkg::WIDTH_REG_W-1:0]  frame_width_reg;
    logic [wmf_pkg::HEIGHT_REG_W-1:0] frame_height_reg;
    logic [wmf_pkg::CHAN_REG_W-1:0]   channel_count_reg;

    logic [wmf_pkg::COL_W-1:0] col_reg, col_next, cur_col;
    logic [wmf_pkg::ROW_W-1:0] row_reg, row_next, cur_row;
    logic [wmf_pkg::CH_W-1:0]  ch_reg, ch_next, cur_ch;

    logic [CW-1:0] fw, fh, fc, w_eff, h_eff, c_eff;
    logic [CW-1:0] col_inc, row_inc, ch_inc;
    logic          col_wrap, row_wrap, ch_wrap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= wmf_pkg::WIDTH_REG_W'(640);
            frame_height_reg  <= wmf_pkg::HEIGHT_REG_W'(480);
            channel_count_reg <= wmf_pkg::CHAN_REG_W'(3);
        end else if (cfg_we) begin
            unique case (cfg_index)
                wmf_pkg::CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_data[wmf_pkg::WIDTH_REG_W-1:0];
                end
                wmf_pkg::CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data[wmf_pkg::HEIGHT_REG_W-1:0];
                end
                wmf_pkg::CFG_CHANNEL_COUNT: begin
                    channel_count_reg <= cfg_data[wmf_pkg::CHAN_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // saturated limits
    always_comb begin
        fw = CW'(frame_width_reg);
        fh = CW'(frame_height_reg);
        fc = CW'(channel_count_reg);
        if (fw < CW'(wmf_pkg::WINDOW)) begin
            w_eff = CW'(wmf_pkg::WINDOW);
        end else if (fw > CW'(wmf_pkg::MAX_WIDTH)) begin
            w_eff = CW'(wmf_pkg::MAX_WIDTH);
        end else begin
            w_eff = fw;
        end
        if (fh < CW'(wmf_pkg::WINDOW)) begin
            h_eff = CW'(wmf_pkg::WINDOW);
        end else if (fh > CW'(wmf_pkg::MAX_HEIGHT)) begin
            h_eff = CW'(wmf_pkg::MAX_HEIGHT);
        end else begin
            h_eff = fh;
        end
        if (fc < CW'(1)) begin
            c_eff = CW'(1);
        end else if (fc > CW'(wmf_pkg::MAX_CHANNELS)) begin
            c_eff = CW'(wmf_pkg::MAX_CHANNELS);
        end else begin
            c_eff = fc;
        end
    end

    always_comb begin
        cur_col = frame_start ? '0 : col_reg;
        cur_row = frame_start ? '0 : row_reg;
        cur_ch  = frame_start ? '0 : ch_reg;

        ch_inc  = CW'(cur_ch) + CW'(1);
        col_inc = CW'(cur_col) + CW'(1);
        row_inc = CW'(cur_row) + CW'(1);
        ch_wrap  = (ch_inc >= c_eff);
        col_wrap = (col_inc >= w_eff);
        row_wrap = (row_inc >= h_eff);

        ch_next  = ch_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            ch_next  = ch_wrap ? '0 : ch_inc[wmf_pkg::CH_W-1:0];
            col_next = cur_col;
            row_next = cur_row;
            if (ch_wrap) begin
                col_next = col_wrap ? '0 : col_inc[wmf_pkg::COL_W-1:0];
                if (col_wrap) begin
                    row_next = row_wrap ? '0 : row_inc[wmf_pkg::ROW_W-1:0];
                end
            end
        end

        pos.ch   = cur_ch;
        pos.col  = cur_col;
        pos.emit = (CW'(cur_row) >= CW'(wmf_pkg::WINDOW - 1))
                && (CW'(cur_col) >= CW'(wmf_pkg::WINDOW - 1));
        pos.last = (CW'(cur_row) == h_eff - CW'(1))
                && (CW'(cur_col) == w_eff - CW'(1))
                && (CW'(cur_ch) == c_eff - CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ch_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            ch_reg  <= ch_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/wmf_median.sv
// wmf_median: selects the middle value of one window by rank counting
// depends on wmf_pkg
`default_nettype none

module wmf_median (
    input  wire wmf_pkg::taps_t                taps,
    output logic [wmf_pkg::SAMPLE_W-1:0]       median
);

    logic [wmf_pkg::TAPS-1:0][wmf_pkg::RANK_W-1:0] rank;

    // rank of tap i is its place in a stable sort; ties go by index
    always_comb begin
        median = '0;
        for (int i = 0; i < wmf_pkg::TAPS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < wmf_pkg::TAPS; j++) begin
                if ((taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i))) begin
                    rank[i] = rank[i] + wmf_pkg::RANK_W'(1);
                end
            end
            if (rank[i] == wmf_pkg::RANK_W'(wmf_pkg::TAPS / 2)) begin
                median = median | taps[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> test/wmf_median_checker.sv
`timescale 1ns / 100ps
// wmf_median_checker: predicts each median item of the window median filter and compares
// every item on the result channel with the oldest prediction; depends on wmf_pkg
module wmf_median_checker
    import wmf_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire cfg_index_t              cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    s_valid,
    input  wire logic                    s_ready,
    input  wire in_item_t                s_item,
    input  wire logic                    m_valid,
    input  wire logic                    m_ready,
    input  wire out_item_t               m_item,
    output int unsigned                  mismatch_count,
    output int unsigned                  medians_owed
);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CHAN_REG_W-1:0]   chan_reg;
    int unsigned             col_pos;
    int unsigned             row_pos;
    int unsigned             ch_pos;
    line_t                   rows_above [MAX_CHANNELS][MAX_WIDTH];
    taps_t                   block [MAX_CHANNELS];
    out_item_t               medians_due [$];
    int unsigned             errors = 0;

    assign mismatch_count = errors;

    function automatic int unsigned limit_to(input int unsigned v, lo, hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // middle value by rank: fewer than half below it, more than half at or below it
    function automatic logic [SAMPLE_W-1:0] middle_value(input taps_t t);
        int below;
        int at_most;
        for (int i = 0; i < TAPS; i++) begin
            below   = 0;
            at_most = 0;
            for (int j = 0; j < TAPS; j++) begin
                if (t[j] < t[i]) below++;
                if (t[j] <= t[i]) at_most++;
            end
            if (below <= TAPS / 2 && at_most > TAPS / 2) return t[i];
        end
        return '0;
    endfunction

    // takes one sample item, returns 1 when it completes a neighbourhood
    function automatic bit step_filter(input in_item_t it, output out_item_t res);
        int unsigned w_lim;
        int unsigned h_lim;
        int unsigned c_lim;
        int unsigned col;
        int unsigned row;
        int unsigned ch;
        column_t     vert;
        bit          produced;
        w_lim = limit_to(width_reg, WINDOW, MAX_WIDTH);
        h_lim = limit_to(height_reg, WINDOW, MAX_HEIGHT);
        c_lim = limit_to(chan_reg, 1, MAX_CHANNELS);
        res   = '0;
        if (it.frame_start) begin
            col_pos = 0;
            row_pos = 0;
            ch_pos  = 0;
        end
        col = col_pos % MAX_WIDTH;
        row = row_pos;
        ch  = ch_pos % MAX_CHANNELS;
        // earlier rows oldest first, new sample at the bottom
        for (int k = 0; k < LINE_DEPTH; k++) vert[k] = rows_above[ch][col][k];
        vert[WINDOW-1] = it.sample;
        for (int k = 0; k < LINE_DEPTH; k++) rows_above[ch][col][k] = vert[k+1];
        for (int i = 0; i < WIN_OLD; i++) block[ch][i] = block[ch][i+WINDOW];
        for (int k = 0; k < WINDOW; k++) block[ch][WIN_OLD+k] = vert[k];
        produced = (row >= WINDOW - 1) && (col >= WINDOW - 1);
        if (produced) begin
            res.median     = middle_value(block[ch]);
            res.frame_done = (row == h_lim - 1) && (col == w_lim - 1) && (ch == c_lim - 1);
        end
        ch_pos++;
        if (ch_pos >= c_lim) begin
            ch_pos = 0;
            col_pos++;
            if (col_pos >= w_lim) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h_lim) row_pos = 0;
            end
        end
        return produced;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            width_reg  = WIDTH_REG_W'(640);
            height_reg = HEIGHT_REG_W'(480);
            chan_reg   = CHAN_REG_W'(3);
            col_pos    = 0;
            row_pos    = 0;
            ch_pos     = 0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                block[c] = '0;
                for (int x = 0; x < MAX_WIDTH; x++) rows_above[c][x] = '0;
            end
            medians_due.delete();
            medians_owed <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:   width_reg  = cfg_data[WIDTH_REG_W-1:0];
                    CFG_FRAME_HEIGHT:  height_reg = cfg_data[HEIGHT_REG_W-1:0];
                    CFG_CHANNEL_COUNT: chan_reg   = cfg_data[CHAN_REG_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (medians_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected median item, expected none, got median %0d done %0b",
                             $time, m_item.median, m_item.frame_done);
                end else begin
                    want = medians_due.pop_front();
                    if (m_item.median !== want.median) begin
                        errors++;
                        $display("%0t: median mismatch, expected %0d, got %0d",
                                 $time, want.median, m_item.median);
                    end
                    if (m_item.frame_done !== want.frame_done) begin
                        errors++;
                        $display("%0t: frame_done mismatch, expected %0b, got %0b",
                                 $time, want.frame_done, m_item.frame_done);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (step_filter(s_item, want)) medians_due.push_back(want);
            end
            medians_owed <= medians_due.size();
        end
    end

endmodule

>>> test/window_median_filter_tb.sv
`timescale 1ns / 100ps
// window_median_filter_tb: stimulus and verdict for the window median filter
// depends on wmf_pkg, window_median_filter and wmf_median_checker
module window_median_filter_tb;
    import wmf_pkg::*;

    localparam int IDLE_PCT      = 38;    // chance in a hundred that a side idles
    localparam int RANDOM_ITEMS  = 1260;  // rough size of the frame-based part
    localparam int PHASE_ITEMS   = 100;   // items per random setting
    localparam int SETTLE_CYCLES = 6;     // wait once no median is owed, leaving some margin
    localparam int WIDE_ITEMS    = 60;    // items sent at the saturated widest frame

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;

    int unsigned mismatch_count;
    int unsigned medians_owed;

    bit          no_gaps = 1'b0;   // set for one stretch where neither side idles
    bit          aligned = 1'b0;   // block's counters known to sit at the frame origin
    int unsigned frame_len;        // items in one whole frame at the current setting
    int unsigned items_sent;       // random items so far

    window_median_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    wmf_median_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .mismatch_count (mismatch_count),
        .medians_owed   (medians_owed)
    );

    // free-running clock, 10 ns period
    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver stalls at random, except during the gap-free stretch
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // sample values: extremes, a narrow cluster for ties, and plain random
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? '1 : '0;
            1:       return SAMPLE_W'(120 + $urandom_range(0, 7));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned fit(input int unsigned v, lo, hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // offers one item; valid is left high on return so back to back items need
    // no second assignment in the same step
    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic first);
        if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid <= 1'b1;
        s_item  <= '{sample: value, frame_start: first};
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender holds off until every predicted median is back and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (medians_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // new setting, written only while the block is idle
    task automatic configure(input logic [CFG_DATA_W-1:0] width_val,
                             input logic [CFG_DATA_W-1:0] height_val,
                             input logic [CFG_DATA_W-1:0] chan_val);
        settle();
        write_reg(CFG_FRAME_WIDTH, width_val);
        write_reg(CFG_FRAME_HEIGHT, height_val);
        write_reg(CFG_CHANNEL_COUNT, chan_val);
        cfg_valid <= 1'b0;
        frame_len = fit(width_val[WIDTH_REG_W-1:0], WINDOW, MAX_WIDTH)
                  * fit(height_val[HEIGHT_REG_W-1:0], WINDOW, MAX_HEIGHT)
                  * fit(chan_val[CHAN_REG_W-1:0], 1, MAX_CHANNELS);
        aligned = 1'b0;
    endtask

    // mostly whole frames of random content; one frame in ten is cut short and
    // the next restarts with frame_start; whole frames may chain without it
    task automatic run_frames(input int unsigned budget);
        int unsigned cut;
        int unsigned done_here;
        done_here = 0;
        while (done_here < budget) begin
            cut = frame_len;
            if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, frame_len);
            for (int unsigned i = 0; i < cut; i++)
                push_sample(pick_sample(), (i == 0) && (!aligned || $urandom_range(0, 3) != 0));
            aligned = (cut == frame_len);
            done_here += cut;
        end
        items_sent += done_here;
    endtask

    initial begin
        int unsigned phase;
        items_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest frame, one channel: one median per frame, always the last
        configure(CFG_DATA_W'(3), CFG_DATA_W'(3), CFG_DATA_W'(1));
        for (int i = 0; i < 9; i++) push_sample('0, i == 0);
        // no frame_start: counters wrapped at the end of the previous frame
        for (int i = 0; i < 9; i++) push_sample('1, 1'b0);
        // alternating extremes, majority at full scale
        for (int i = 0; i < 9; i++) push_sample(i[0] ? '0 : '1, i == 0);

        // all-ones registers saturate to the widest and tallest frame; no median
        // may come out while the first row is still running
        configure('1, '1, CFG_DATA_W'(1));
        for (int i = 0; i < WIDE_ITEMS; i++) push_sample(pick_sample(), i == 0);

        // zero registers saturate to the smallest frame
        configure('0, '0, '0);
        run_frames(PHASE_ITEMS);
        // bits above each register's width are dropped
        configure(CFG_DATA_W'('h1805), CFG_DATA_W'(4), CFG_DATA_W'('h1FFA));
        run_frames(PHASE_ITEMS);
        // channel count beyond the maximum
        configure(CFG_DATA_W'(4), CFG_DATA_W'(5), CFG_DATA_W'(7));
        run_frames(PHASE_ITEMS);

        // random settings, now and then below the minimum
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            configure(($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                  : CFG_DATA_W'($urandom_range(3, 10)),
                      ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                  : CFG_DATA_W'($urandom_range(3, 5)),
                      CFG_DATA_W'($urandom_range(0, 7)));
            no_gaps = (phase == 3);
            run_frames(PHASE_ITEMS);
            phase++;
        end
        no_gaps = 1'b0;

        settle();
        if (mismatch_count == 0 && medians_owed == 0) begin
            $display("window_median_filter_tb passed");
        end else begin
            $display("window_median_filter_tb failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("window_median_filter_tb failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/wmf_pkg.sv
rtl/core/wmf_ram.sv
rtl/core/wmf_position.sv
rtl/core/wmf_median.sv
rtl/core/window_median_filter.sv
test/wmf_median_checker.sv
test/window_median_filter_tb.sv
